@@ src/plb_pkg.sv @@
// ----------------------------------------------------------------------------
// plb_pkg: shared definitions for the positional list buffer
// Field layout of the stream words, request and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  // input word fields
  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int FUNC_LO  = 0;
  localparam int VALUE_LO = FUNC_LO + FUNC_W;
  localparam int POS_LO   = VALUE_LO + VALUE_W;
  localparam int IN_W     = 40;

  // output word fields
  localparam int DOUT_W  = 32;
  localparam int LEN_W   = 5;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 40;
  localparam int OUT_PAD = OUT_W - DOUT_W - LEN_W - STAT_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND  = 3'd0,
    FN_PREPEND = 3'd1,
    FN_POP     = 3'd2,
    FN_INSERT  = 3'd3,
    FN_REMOVE  = 3'd4,
    FN_READ    = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // memory read address source
  typedef enum logic [1:0] {
    RD_TGT    = 2'd0,
    RD_PTR_M1 = 2'd1,
    RD_PTR_P1 = 2'd2,
    RD_TAIL   = 2'd3
  } rd_sel_e;

  // memory write address and data source
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_SHIFT = 2'd1,
    WR_TGT   = 2'd2,
    WR_TAIL  = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic    take;          // capture the input word
    logic    stat_cap;      // latch request status
    logic    data_clr;
    logic    data_cap;      // latch memory read data as result
    logic    ptr_from_cnt;
    logic    ptr_from_tgt;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    status_e           status;
    logic              up_more;   // shift toward tail not yet at target
    logic              dn_more;   // shift toward head not yet at tail
    logic              out_free;  // result register can take a word
  } sts_t;

endpackage

@@ src/plb_ctrl.sv @@
// ----------------------------------------------------------------------------
// plb_ctrl: request sequencer
// One-hot state machine that decodes a request and steps the datapath
// through tail and target writes, entry shifts and reads.
// ----------------------------------------------------------------------------
module plb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  plb_pkg::sts_t sts_i,
  output plb_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_UP_CHK = 8'b0000_0100,
    S_UP_WR  = 8'b0000_1000,
    S_DN_CHK = 8'b0001_0000,
    S_DN_WR  = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.stat_cap = 1'b1;
        cmd_o.data_clr = 1'b1;
        state_d        = S_DONE;
        if (sts_i.status == plb_pkg::ST_OK) begin
          case (sts_i.func)
            plb_pkg::FN_APPEND: begin
              cmd_o.wr_sel  = plb_pkg::WR_TAIL;
              cmd_o.cnt_inc = 1'b1;
            end
            plb_pkg::FN_PREPEND, plb_pkg::FN_INSERT: begin
              cmd_o.ptr_from_cnt = 1'b1;
              state_d            = S_UP_CHK;
            end
            plb_pkg::FN_POP: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = plb_pkg::RD_TAIL;
              cmd_o.cnt_dec = 1'b1;
              state_d       = S_RDWAIT;
            end
            plb_pkg::FN_REMOVE: begin
              cmd_o.ptr_from_tgt = 1'b1;
              state_d            = S_DN_CHK;
            end
            plb_pkg::FN_READ: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = plb_pkg::RD_TGT;
              state_d      = S_RDWAIT;
            end
            default: begin
              state_d = S_DONE;   // unused codes: no change
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (sts_i.up_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = plb_pkg::RD_PTR_M1;
          state_d      = S_UP_WR;
        end else begin
          cmd_o.wr_sel  = plb_pkg::WR_TGT;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_UP_WR: begin
        cmd_o.wr_sel  = plb_pkg::WR_SHIFT;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_UP_CHK;
      end
      S_DN_CHK: begin
        if (sts_i.dn_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = plb_pkg::RD_PTR_P1;
          state_d      = S_DN_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DN_WR: begin
        cmd_o.wr_sel  = plb_pkg::WR_SHIFT;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_DN_CHK;
      end
      S_RDWAIT: begin
        cmd_o.data_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_take_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("accepted word not decoded next cycle");

  a_cnt_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.cnt_inc && cmd_o.cnt_dec))
    else $error("count incremented and decremented together");

  a_read_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> (state_q == S_UP_WR || state_q == S_DN_WR || state_q == S_RDWAIT))
    else $error("memory read issued with no consumer");
`endif

endmodule

@@ src/plb_dp.sv @@
// ----------------------------------------------------------------------------
// plb_dp: list storage and result path
// Entry memory with registered read, count and shift pointer, request
// status decode and the output word register.
// ----------------------------------------------------------------------------
module plb_dp #(
  parameter int CAPACITY  = plb_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = plb_pkg::WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [plb_pkg::IN_W-1:0]  in_data_i,
  input  plb_pkg::cmd_t             cmd_i,
  output plb_pkg::sts_t             sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [plb_pkg::OUT_W-1:0] out_data_o
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > plb_pkg::POS_W) ? CNT_W : plb_pkg::POS_W) + 1;

  logic [WORD_BITS-1:0]        mem_q [CAPACITY];
  logic [WORD_BITS-1:0]        rdata_q;
  logic [plb_pkg::FUNC_W-1:0]  func_q;
  logic [WORD_BITS-1:0]        val_q;
  logic [plb_pkg::POS_W-1:0]   pos_q;
  logic [WORD_BITS-1:0]        data_q;
  plb_pkg::status_e            stat_q;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [CNT_W-1:0]            ptr_q, ptr_d;
  logic                        out_valid_q;
  logic [plb_pkg::OUT_W-1:0]   out_data_q;

  logic [CMP_W-1:0]            pos_c, cnt_c;
  logic [AW-1:0]               tgt;
  logic                        full, empty, bad_ins, bad_at;
  plb_pkg::status_e            status;
  logic [AW-1:0]               raddr, waddr;
  logic [WORD_BITS-1:0]        wdata;
  logic                        wr_en;
  logic [plb_pkg::DOUT_W-1:0]  dout;
  logic [plb_pkg::LEN_W-1:0]   len;

  // request capture; value is sign-extended or cut to the stored width
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q <= in_data_i[plb_pkg::FUNC_LO +: plb_pkg::FUNC_W];
      val_q  <= WORD_BITS'(signed'(in_data_i[plb_pkg::VALUE_LO +: plb_pkg::VALUE_W]));
      pos_q  <= in_data_i[plb_pkg::POS_LO +: plb_pkg::POS_W];
    end
  end

  // status decode
  assign pos_c   = CMP_W'(pos_q);
  assign cnt_c   = CMP_W'(cnt_q);
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign bad_ins = (pos_q == '0) || (pos_c > cnt_c + 1'b1);
  assign bad_at  = (pos_q == '0) || (pos_c > cnt_c);
  assign tgt     = (func_q == plb_pkg::FN_PREPEND) ? '0 : AW'(pos_c - 1'b1);

  always_comb begin
    case (func_q)
      plb_pkg::FN_APPEND,
      plb_pkg::FN_PREPEND: status = full ? plb_pkg::ST_FULL : plb_pkg::ST_OK;
      plb_pkg::FN_POP:     status = empty ? plb_pkg::ST_EMPTY : plb_pkg::ST_OK;
      plb_pkg::FN_INSERT:  status = full ? plb_pkg::ST_FULL :
                                    (bad_ins ? plb_pkg::ST_RANGE : plb_pkg::ST_OK);
      plb_pkg::FN_REMOVE,
      plb_pkg::FN_READ:    status = empty ? plb_pkg::ST_EMPTY :
                                    (bad_at ? plb_pkg::ST_RANGE : plb_pkg::ST_OK);
      default:             status = plb_pkg::ST_OK;
    endcase
  end

  assign sts_o.func     = func_q;
  assign sts_o.status   = status;
  assign sts_o.up_more  = (ptr_q > CNT_W'(tgt));
  assign sts_o.dn_more  = (CMP_W'(ptr_q) + 1'b1 < cnt_c);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // memory address and data select
  always_comb begin
    case (cmd_i.rd_sel)
      plb_pkg::RD_TGT:    raddr = tgt;
      plb_pkg::RD_PTR_M1: raddr = AW'(ptr_q - 1'b1);
      plb_pkg::RD_PTR_P1: raddr = AW'(ptr_q + 1'b1);
      plb_pkg::RD_TAIL:   raddr = AW'(cnt_q - 1'b1);
      default:            raddr = tgt;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    case (cmd_i.wr_sel)
      plb_pkg::WR_SHIFT: begin
        waddr = AW'(ptr_q);
        wdata = rdata_q;
      end
      plb_pkg::WR_TGT: begin
        waddr = tgt;
        wdata = val_q;
      end
      plb_pkg::WR_TAIL: begin
        waddr = AW'(cnt_q);
        wdata = val_q;
      end
      default: begin
        wr_en = 1'b0;
        waddr = tgt;
        wdata = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result data and status
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_clr) begin
      data_q <= '0;
    end else if (cmd_i.data_cap) begin
      data_q <= rdata_q;
    end
    if (cmd_i.stat_cap) begin
      stat_q <= status;
    end
  end

  // count and shift pointer
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
    ptr_d = ptr_q;
    if (cmd_i.ptr_from_cnt) begin
      ptr_d = cnt_q;
    end else if (cmd_i.ptr_from_tgt) begin
      ptr_d = CNT_W'(tgt);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - 1'b1;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  // output word register
  assign dout = plb_pkg::DOUT_W'(signed'(data_q));
  assign len  = plb_pkg::LEN_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {{plb_pkg::OUT_PAD{1'b0}}, stat_q, len, dout};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |->
      (cnt_q == CNT_W'($past(cnt_q) + 1'b1) || cnt_q == CNT_W'($past(cnt_q) - 1'b1)))
    else $error("entry count moved by more than one");

  // new words land only while there is room; shifts down may run on a full list
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_sel == plb_pkg::WR_TAIL || cmd_i.wr_sel == plb_pkg::WR_TGT) |->
      cnt_q < CNT_W'(CAPACITY))
    else $error("entry written while list full");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken word");
`endif

endmodule

@@ src/positional_list_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_buffer_unit: bounded ordered list of signed words
// Requests come in on the slave stream, one result word per request goes
// out on the master stream.
// Usage:
//   - s_axis carries one request word: func, value, position. A word is
//     taken only while the unit is idle.
//   - m_axis returns data_out, length and status for every request, in
//     request order.
//   - From accept to result valid, every request passes the decode and
//     done states; pop and read add a read wait, and insert, prepend and
//     remove add a read-issuing check and a write state for each of the N
//     entries shifted (up to CAPACITY-1). Each shifted entry costs one memory
//     read and one memory write on the entry memory. The next request can be
//     taken in the cycle after the result is loaded.
//   - The result sits in an output register; a stalled receiver holds the
//     unit in its final state until the register frees, the list is not
//     touched meanwhile.
//   - Reset empties the list (count to zero); entry contents are left as
//     they are and are only read after being written.
// ----------------------------------------------------------------------------
module positional_list_buffer_unit #(
  parameter int CAPACITY  = plb_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = plb_pkg::WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [plb_pkg::IN_W-1:0]  s_axis_tdata,  // func[2:0], value[34:3], position[39:35]
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [plb_pkg::OUT_W-1:0] m_axis_tdata   // data_out[31:0], length[36:32],
                                                    // status[38:37], zero[39]
);

  plb_pkg::cmd_t cmd;   // controller -> datapath
  plb_pkg::sts_t sts;   // datapath -> controller

  // sequencer: decode, shift loops, result handoff
  plb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, count, status decode, output register
  plb_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
